>>> rtl/irft_pkg.sv
`timescale 1ns / 1ps

package irft_pkg;

	// Register map of the configuration port
	typedef enum logic [2:0] {
		CFG_CARRIER_HALF  = 3'd0,
		CFG_START_MARK    = 3'd1,
		CFG_START_SPACE   = 3'd2,
		CFG_BIT_MARK      = 3'd3,
		CFG_ONE_SPACE     = 3'd4,
		CFG_ZERO_SPACE    = 3'd5
	} cfg_reg_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0]  CARRIER_HALF_RST = 8'd13;
	localparam logic [9:0]  START_MARK_RST   = 10'd173;
	localparam logic [15:0] START_SPACE_RST  = 16'd4500;
	localparam logic [7:0]  BIT_MARK_RST     = 8'd21;
	localparam logic [15:0] ONE_SPACE_RST    = 16'd1690;
	localparam logic [15:0] ZERO_SPACE_RST   = 16'd560;

	localparam logic [5:0] FRAME_BITS = 6'd32;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_START_MARK  = 3'd1,
		PH_START_SPACE = 3'd2,
		PH_BIT_MARK    = 3'd3,
		PH_BIT_SPACE   = 3'd4,
		PH_STOP_MARK   = 3'd5,
		PH_STOP_SPACE  = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0]  carrier_half_us;
		logic [9:0]  start_mark_periods;
		logic [15:0] start_space_us;
		logic [7:0]  bit_mark_periods;
		logic [15:0] one_space_us;
		logic [15:0] zero_space_us;
	} irft_cfg_t;

	typedef struct packed {
		logic led_on;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} irft_res_t;

	// a count of zero behaves as one
	function automatic logic [7:0] nz8(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	function automatic logic [9:0] nz10(input logic [9:0] v);
		return (v == 10'd0) ? 10'd1 : v;
	endfunction

	function automatic logic [15:0] nz16(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage

>>> rtl/irft_ifs.sv
`timescale 1ns / 1ps

interface irft_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] address;
	logic [7:0]  command_byte;

	modport source (output valid, cmd, address, command_byte, input ready);
	modport sink   (input valid, cmd, address, command_byte, output ready);
endinterface

interface irft_res_if;
	logic valid;
	logic ready;
	logic led_on;
	logic busy_res;
	logic frame_done;
	logic rejected;

	modport source (output valid, led_on, busy_res, frame_done, rejected, input ready);
	modport sink   (input valid, led_on, busy_res, frame_done, rejected, output ready);
endinterface

interface irft_cfg_if import irft_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/irft_cfg_regs.sv
`timescale 1ns / 1ps

module irft_cfg_regs import irft_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output irft_cfg_t             cfg
);

	irft_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carrier_half_us    <= CARRIER_HALF_RST;
			cfg_q.start_mark_periods <= START_MARK_RST;
			cfg_q.start_space_us     <= START_SPACE_RST;
			cfg_q.bit_mark_periods   <= BIT_MARK_RST;
			cfg_q.one_space_us       <= ONE_SPACE_RST;
			cfg_q.zero_space_us      <= ZERO_SPACE_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				CFG_CARRIER_HALF: cfg_q.carrier_half_us    <= wr_data[7:0];
				CFG_START_MARK:   cfg_q.start_mark_periods <= wr_data[9:0];
				CFG_START_SPACE:  cfg_q.start_space_us     <= wr_data;
				CFG_BIT_MARK:     cfg_q.bit_mark_periods   <= wr_data[7:0];
				CFG_ONE_SPACE:    cfg_q.one_space_us       <= wr_data;
				CFG_ZERO_SPACE:   cfg_q.zero_space_us      <= wr_data;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/irft_seq.sv
`timescale 1ns / 1ps

module irft_seq import irft_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  irft_cfg_t   cfg,
	input  logic        tick,
	input  logic        cmd,
	input  logic [15:0] address,
	input  logic [7:0]  command_byte,
	output irft_res_t   res
);

	phase_t      phase_q;
	logic [31:0] shift_q;
	logic [5:0]  bits_q;
	logic [9:0]  per_q;
	logic [7:0]  half_q;
	logic [15:0] space_q;
	logic        lvl_q;

	phase_t      ph, ph_n;
	logic [31:0] sh, sh_n;
	logic [5:0]  bl, bl_n;
	logic [9:0]  pl, pl_n, p_dec;
	logic [7:0]  hl, hl_n, h_dec, half_rld;
	logic [15:0] sl, sl_n, s_dec;
	logic        lv, lv_n;
	logic        start;

	assign half_rld = nz8(cfg.carrier_half_us);

	always_comb begin
		start = cmd && (phase_q == PH_IDLE);
		res   = '0;
		res.rejected = cmd && (phase_q != PH_IDLE);

		// state as seen by this tick, with a new frame loaded
		ph = phase_q;
		sh = shift_q;
		bl = bits_q;
		pl = per_q;
		hl = half_q;
		sl = space_q;
		lv = lvl_q;
		if (start) begin
			ph = PH_START_MARK;
			sh = {address, command_byte, ~command_byte};
			bl = FRAME_BITS;
			pl = nz10(cfg.start_mark_periods);
			hl = half_rld;
			lv = 1'b1;
		end

		h_dec = (hl != 8'd0) ? hl - 8'd1 : 8'd0;
		p_dec = (pl != 10'd0) ? pl - 10'd1 : 10'd0;
		s_dec = (sl != 16'd0) ? sl - 16'd1 : 16'd0;

		ph_n = ph;
		sh_n = sh;
		bl_n = bl;
		pl_n = pl;
		hl_n = hl;
		sl_n = sl;
		lv_n = lv;

		unique case (ph)
			PH_START_MARK, PH_BIT_MARK, PH_STOP_MARK: begin
				res.busy_res = 1'b1;
				res.led_on   = lv;
				if (h_dec != 8'd0) begin
					hl_n = h_dec;
				end else begin
					hl_n = half_rld;
					if (lv) begin
						lv_n = 1'b0;
					end else begin
						pl_n = p_dec;
						if (p_dec != 10'd0) begin
							lv_n = 1'b1;
						end else if (ph == PH_START_MARK) begin
							ph_n = PH_START_SPACE;
							sl_n = nz16(cfg.start_space_us);
						end else if (ph == PH_BIT_MARK) begin
							// MSB leaves the shifter and picks the space length
							ph_n = PH_BIT_SPACE;
							sh_n = {sh[30:0], 1'b0};
							bl_n = (bl != 6'd0) ? bl - 6'd1 : 6'd0;
							sl_n = nz16(sh[31] ? cfg.one_space_us : cfg.zero_space_us);
						end else begin
							ph_n = PH_STOP_SPACE;
							sl_n = nz16(cfg.one_space_us);
						end
					end
				end
			end
			PH_START_SPACE, PH_BIT_SPACE: begin
				res.busy_res = 1'b1;
				sl_n = s_dec;
				if (s_dec == 16'd0) begin
					ph_n = (bl != 6'd0) ? PH_BIT_MARK : PH_STOP_MARK;
					pl_n = {2'b00, nz8(cfg.bit_mark_periods)};
					hl_n = half_rld;
					lv_n = 1'b1;
				end
			end
			PH_STOP_SPACE: begin
				res.busy_res = 1'b1;
				sl_n = s_dec;
				if (s_dec == 16'd0) begin
					res.frame_done = 1'b1;
					ph_n = PH_IDLE;
					lv_n = 1'b0;
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			shift_q <= '0;
			bits_q  <= '0;
			per_q   <= '0;
			half_q  <= '0;
			space_q <= '0;
			lvl_q   <= 1'b0;
		end else if (tick) begin
			phase_q <= ph_n;
			shift_q <= sh_n;
			bits_q  <= bl_n;
			per_q   <= pl_n;
			half_q  <= hl_n;
			space_q <= sl_n;
			lvl_q   <= lv_n;
		end
	end

endmodule

>>> rtl/irft_out_stage.sv
`timescale 1ns / 1ps

module irft_out_stage import irft_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  irft_res_t push_data,
	output logic      push_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output irft_res_t out_data
);

	logic      out_v_q;
	logic      skid_v_q;
	irft_res_t out_d_q;
	irft_res_t skid_d_q;

	assign push_ready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_d_q <= skid_v_q ? skid_d_q : push_data;
		end else if (push) begin
			skid_d_q <= push_data;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

endmodule

>>> rtl/ir_remote_frame_transmitter_core.sv
`timescale 1ns / 1ps

// channel | dir | beat carries                               | accepted when
// item    | in  | cmd, address, command_byte                 | valid && ready
// res     | out | led_on, busy_res, frame_done, rejected     | valid && ready
// cfg     | in  | index, data (register write)               | valid && ready
//
// One item is one 1 us tick; an item is taken every clock while res drains.
// Each tick's result is registered in the output register, or in the skid entry while res is stalled.
// The state update and result logic run between the sequencer registers and the
// output register; a skid entry holds one more result while res is stalled.
// item.ready drops only when both output register and skid entry are full.
// Reset: idle, registers back to defaults. cfg.ready is always high.

module ir_remote_frame_transmitter_core import irft_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	irft_item_if.sink   item,
	irft_res_if.source  res,
	irft_cfg_if.sink    cfg
);

	irft_cfg_t cfg_regs;
	irft_res_t tick_res;
	irft_res_t out_res;
	logic      push;
	logic      push_ready;

	assign cfg.ready = 1'b1;

	irft_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// frame sequencer advances once per accepted tick beat
	assign item.ready = push_ready;
	assign push       = item.valid && push_ready;

	irft_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_regs),
		.tick         (push),
		.cmd          (item.cmd),
		.address      (item.address),
		.command_byte (item.command_byte),
		.res          (tick_res)
	);

	irft_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (tick_res),
		.push_ready (push_ready),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_data   (out_res)
	);

	assign res.led_on     = out_res.led_on;
	assign res.busy_res   = out_res.busy_res;
	assign res.frame_done = out_res.frame_done;
	assign res.rejected   = out_res.rejected;

endmodule

>>> rtl/irft_checker.sv
`timescale 1ns / 1ps

module irft_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// backpressure on item only while a result is pending
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("item stalled with empty output");

	// item beat into an empty output shows up next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> out_valid)
		else $error("result missing one cycle after item beat");

	// ready falls only after a beat taken while the output was stalled
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && out_valid && !out_ready))
		else $error("item ready fell without a stalled beat");

endmodule

bind ir_remote_frame_transmitter_core irft_checker u_irft_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (res.valid),
	.out_ready (res.ready)
);

>>> bench/ir_remote_frame_transmitter_core_test.sv
`timescale 1ns / 1ps

// Bench for the IR frame transmitter core.
// The driver feeds tick beats from a queue that the stimulus block fills.
// The monitor runs a local model of the sequencer on every accepted tick.
// Every result beat is checked field by field against the oldest prediction.
module ir_remote_frame_transmitter_core_test;
	import irft_pkg::*;

	localparam int STALL_LIMIT = 2000;  // cycles with no beat on any channel
	localparam int DRAIN_HOLD  = 8;     // quiet cycles after the last result

	typedef struct packed {
		logic        cmd;
		logic [15:0] address;
		logic [7:0]  command_byte;
	} tick_t;

	logic clk;
	logic arst_n;

	irft_item_if item_ch();
	irft_res_if  res_ch();
	irft_cfg_if  cfg_ch();

	ir_remote_frame_transmitter_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// ticks waiting for the driver, and LED results waiting for the DUT
	tick_t     tick_queue[$];
	irft_res_t led_expect_q[$];
	tick_t     drv_beat;

	// idle rates in percent, changed between stimulus phases
	int unsigned send_gap_pct;
	int unsigned take_gap_pct;

	// local copy of the register file and of the sequencer state
	irft_cfg_t  reg_copy;
	phase_t     seq_phase;
	logic [31:0] seq_frame;
	logic [5:0] seq_bits;
	logic [9:0] seq_periods;
	logic [7:0] seq_half;
	logic [15:0] seq_space;
	logic       seq_level;

	int unsigned errors;
	int unsigned ticks_checked;
	int unsigned frames_ended;
	int unsigned sends_refused;
	int unsigned reg_writes;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Sequencer model
	// ---------------------------------------------------------------

	// Marks latch their period count; the half-period count is reloaded
	// from the live register at every carrier edge. Zero counts act as one.
	task automatic open_mark(input phase_t p, input logic [9:0] periods);
		seq_phase   = p;
		seq_periods = (periods == 10'd0) ? 10'd1 : periods;
		seq_half    = (reg_copy.carrier_half_us == 8'd0) ? 8'd1 : reg_copy.carrier_half_us;
		seq_level   = 1'b1;
	endtask

	task automatic open_space(input phase_t p, input logic [15:0] ticks);
		seq_phase = p;
		seq_space = (ticks == 16'd0) ? 16'd1 : ticks;
	endtask

	task automatic led_tick(input tick_t t, output irft_res_t r);
		logic mark_over;
		logic data_bit;
		mark_over = 1'b0;
		r = '0;
		// a send only loads when idle; otherwise it is refused and the
		// tick still advances the running frame
		if (t.cmd) begin
			if (seq_phase == PH_IDLE) begin
				seq_frame = {t.address, t.command_byte, ~t.command_byte};
				seq_bits  = FRAME_BITS;
				open_mark(PH_START_MARK, reg_copy.start_mark_periods);
			end else begin
				r.rejected = 1'b1;
			end
		end
		case (seq_phase)
			PH_START_MARK, PH_BIT_MARK, PH_STOP_MARK: begin
				r.busy_res = 1'b1;
				r.led_on   = seq_level;
				if (seq_half != 8'd0)
					seq_half = seq_half - 8'd1;
				if (seq_half == 8'd0) begin
					seq_half = (reg_copy.carrier_half_us == 8'd0) ? 8'd1 :
						reg_copy.carrier_half_us;
					if (seq_level) begin
						seq_level = 1'b0;
					end else begin
						if (seq_periods != 10'd0)
							seq_periods = seq_periods - 10'd1;
						if (seq_periods == 10'd0)
							mark_over = 1'b1;
						else
							seq_level = 1'b1;
					end
				end
				if (mark_over) begin
					case (seq_phase)
						PH_START_MARK: begin
							open_space(PH_START_SPACE, reg_copy.start_space_us);
						end
						PH_BIT_MARK: begin
							data_bit  = seq_frame[31];
							seq_frame = {seq_frame[30:0], 1'b0};
							if (seq_bits != 6'd0)
								seq_bits = seq_bits - 6'd1;
							open_space(PH_BIT_SPACE, data_bit ? reg_copy.one_space_us :
								reg_copy.zero_space_us);
						end
						default: begin
							// stop bit is always sent as a one
							open_space(PH_STOP_SPACE, reg_copy.one_space_us);
						end
					endcase
				end
			end
			PH_START_SPACE, PH_BIT_SPACE: begin
				r.busy_res = 1'b1;
				if (seq_space != 16'd0)
					seq_space = seq_space - 16'd1;
				if (seq_space == 16'd0) begin
					if (seq_bits != 6'd0)
						open_mark(PH_BIT_MARK, {2'b00, reg_copy.bit_mark_periods});
					else
						open_mark(PH_STOP_MARK, {2'b00, reg_copy.bit_mark_periods});
				end
			end
			PH_STOP_SPACE: begin
				r.busy_res = 1'b1;
				if (seq_space != 16'd0)
					seq_space = seq_space - 16'd1;
				if (seq_space == 16'd0) begin
					r.frame_done = 1'b1;
					seq_phase    = PH_IDLE;
					seq_level    = 1'b0;
				end
			end
			default: begin
				seq_phase = PH_IDLE;
			end
		endcase
	endtask

	task automatic report(input string msg);
		$display("MISMATCH result %0d: %s", ticks_checked, msg);
		errors++;
	endtask

	// ---------------------------------------------------------------
	// Driver, receiver, monitor, watchdog
	// ---------------------------------------------------------------

	// hold a beat until taken; a gap only opens when the line is free
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (tick_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				drv_beat = tick_queue.pop_front();
				item_ch.valid        <= 1'b1;
				item_ch.cmd          <= drv_beat.cmd;
				item_ch.address      <= drv_beat.address;
				item_ch.command_byte <= drv_beat.command_byte;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= take_gap_pct);
	end

	// prediction and checking share one block so the expectation queue
	// is never touched by two processes in the same step
	always @(posedge clk) begin
		tick_t     got_tick;
		irft_res_t want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				got_tick = {item_ch.cmd, item_ch.address, item_ch.command_byte};
				led_tick(got_tick, want);
				if (want.frame_done)
					frames_ended++;
				if (want.rejected)
					sends_refused++;
				led_expect_q.push_back(want);
			end
			if (res_ch.valid && res_ch.ready) begin
				if (led_expect_q.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					want = led_expect_q.pop_front();
					if (res_ch.led_on !== want.led_on)
						report($sformatf("led_on got %b want %b", res_ch.led_on,
							want.led_on));
					if (res_ch.busy_res !== want.busy_res)
						report($sformatf("busy_res got %b want %b", res_ch.busy_res,
							want.busy_res));
					if (res_ch.frame_done !== want.frame_done)
						report($sformatf("frame_done got %b want %b", res_ch.frame_done,
							want.frame_done));
					if (res_ch.rejected !== want.rejected)
						report($sformatf("rejected got %b want %b", res_ch.rejected,
							want.rejected));
				end
				ticks_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TIMEOUT: no beat for %0d cycles", STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// register write; the local copy changes on the accepting edge
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_CARRIER_HALF: reg_copy.carrier_half_us    = v[7:0];
			CFG_START_MARK:   reg_copy.start_mark_periods = v[9:0];
			CFG_START_SPACE:  reg_copy.start_space_us     = v;
			CFG_BIT_MARK:     reg_copy.bit_mark_periods   = v[7:0];
			CFG_ONE_SPACE:    reg_copy.one_space_us       = v;
			CFG_ZERO_SPACE:   reg_copy.zero_space_us      = v;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic write_all(input logic [15:0] ch, input logic [15:0] sm,
		input logic [15:0] ss, input logic [15:0] bm, input logic [15:0] os,
		input logic [15:0] zs);
		write_reg(CFG_CARRIER_HALF, ch);
		write_reg(CFG_START_MARK, sm);
		write_reg(CFG_START_SPACE, ss);
		write_reg(CFG_BIT_MARK, bm);
		write_reg(CFG_ONE_SPACE, os);
		write_reg(CFG_ZERO_SPACE, zs);
	endtask

	task automatic push_tick(input logic c, input logic [15:0] a, input logic [7:0] b);
		tick_t t;
		t.cmd = c;
		t.address = a;
		t.command_byte = b;
		tick_queue.push_back(t);
	endtask

	task automatic push_idle(input int n);
		repeat (n) push_tick(1'b0, 16'($urandom), 8'($urandom));
	endtask

	// sender holds off until every predicted result has come back
	task automatic settle();
		do @(negedge clk);
		while (tick_queue.size() != 0 || item_ch.valid || led_expect_q.size() != 0);
	endtask

	// queued sends are taken first so the model phase is current
	task automatic run_out(input int chunk);
		settle();
		while (seq_phase != PH_IDLE) begin
			push_idle(chunk);
			settle();
		end
	endtask

	// single-step to the tick that closes the stop space
	task automatic step_to_last_stop_tick();
		while (seq_phase != PH_IDLE &&
			!(seq_phase == PH_STOP_SPACE && seq_space == 16'd1)) begin
			push_idle(1);
			settle();
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.cmd = 1'b0;
		item_ch.address = '0;
		item_ch.command_byte = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		errors = 0;
		ticks_checked = 0;
		frames_ended = 0;
		sends_refused = 0;
		reg_writes = 0;
		quiet_cycles = 0;
		send_gap_pct = 9;
		take_gap_pct = 53;

		reg_copy.carrier_half_us    = CARRIER_HALF_RST;
		reg_copy.start_mark_periods = START_MARK_RST;
		reg_copy.start_space_us     = START_SPACE_RST;
		reg_copy.bit_mark_periods   = BIT_MARK_RST;
		reg_copy.one_space_us       = ONE_SPACE_RST;
		reg_copy.zero_space_us      = ZERO_SPACE_RST;
		seq_phase   = PH_IDLE;
		seq_frame   = '0;
		seq_bits    = '0;
		seq_periods = '0;
		seq_half    = '0;
		seq_space   = '0;
		seq_level   = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle ticks give an all-zero result
		push_idle(3);
		settle();

		// frame on reset timing, all-ones address, zero command; a second
		// send lands in the start mark and must be refused
		push_tick(1'b1, 16'hFFFF, 8'h00);
		push_idle(40);
		push_tick(1'b1, 16'h0000, 8'hFF);
		push_idle(20);
		settle();

		// writes while the frame runs: carrier applies at the next edge,
		// the rest at the next mark or space that opens
		write_reg(CFG_CARRIER_HALF, 16'd1);
		write_reg(CFG_START_SPACE, 16'd3);
		write_reg(CFG_BIT_MARK, 16'd1);
		write_reg(CFG_ONE_SPACE, 16'd3);
		write_reg(CFG_ZERO_SPACE, 16'd1);

		// send on the closing tick of the stop space: refused and done
		// together, then a send right on the next idle tick
		step_to_last_stop_tick();
		push_tick(1'b1, 16'($urandom), 8'($urandom));
		settle();
		write_reg(CFG_START_MARK, 16'd2);
		push_tick(1'b1, 16'h0000, 8'hFF);
		run_out(16);

		// every count at zero behaves as one
		write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		push_tick(1'b1, 16'hA5C3, 8'h3C);
		run_out(16);

		// random part: three idle profiles, three register sets each
		for (int prof = 0; prof < 3; prof++) begin
			send_gap_pct = (prof == 0) ? 9 : (prof == 1) ? 53 : 0;
			take_gap_pct = (prof == 0) ? 53 : (prof == 1) ? 9 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				settle();
				write_all(16'($urandom_range(0, 2)), 16'($urandom_range(0, 4)),
					16'($urandom_range(0, 6)), 16'($urandom_range(0, 2)),
					16'($urandom_range(0, 4)), 16'($urandom_range(0, 2)));
				for (int k = 0; k < 60; k++)
					push_tick($urandom_range(29) == 0, 16'($urandom), 8'($urandom));
			end
		end

		settle();
		repeat (DRAIN_HOLD) @(posedge clk);

		$display("run: %0d ticks checked, %0d frames ended, %0d sends refused",
			ticks_checked, frames_ended, sends_refused);
		$display("run: %0d register writes, mid-frame and zero counts included",
			reg_writes);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
